// ===== src/pdt_pkg.sv =====
package pdt_pkg;

    localparam int unsigned CIVIL_STAGES = 8;

    localparam logic [25:0] RECIP_675  = 26'((64'd1 << 35) / 64'd675);
    localparam logic [18:0] RECIP_1460 = 19'((64'd1 << 29) / 64'd1460);
    localparam logic [18:0] RECIP_365  = 19'((64'd1 << 27) / 64'd365);
    localparam logic [16:0] RECIP_7    = 17'((64'd1 << 19) / 64'd7);

    localparam logic [9:0]  DAY_CHUNK   = 10'd675;
    localparam logic [19:0] EPOCH_SHIFT = 20'd719468;
    localparam logic [19:0] ERA5_BASE   = 20'd730485;
    localparam logic [19:0] ERA4_BASE   = 20'd584388;
    localparam logic [17:0] QUAD_DAYS   = 18'd1460;
    localparam logic [17:0] CENT_DAYS   = 18'd36524;
    localparam logic [17:0] ERA_LAST    = 18'd146096;
    localparam logic [17:0] YEAR_DAYS   = 18'd365;
    localparam logic [15:0] WEEKDAY_BIAS = 16'd5;
    localparam logic [15:0] WEEK_DAYS   = 16'd7;

    localparam logic [3:0]  MONTH_MARCH    = 4'd3;
    localparam logic [3:0]  MONTH_NOVEMBER = 4'd11;
    localparam logic [16:0] SPRING_SOD     = 17'd36000;
    localparam logic [16:0] FALL_SOD       = 17'd32400;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] mday;
    } date_t;

    // First day of each month in a year that starts in March.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

// ===== src/pacific_daylight_time_detect_unit.sv =====
// Channel   Direction  Ports                              Word
// s_        in         s_valid s_ready s_utc_seconds       UTC seconds since 1970
// m_        out        m_valid m_ready m_daylight          Daylight time flag
//
// The pipeline has thirteen register stages, and one word is accepted in every
// cycle in which the output word is not held.
// The divider and calendar stages are each a single constant multiply or
// compare step.
// Reset is synchronous and active low, and it clears only the valid bits.
// When the output word is held, the whole pipeline stalls and s_ready drops.
module pacific_daylight_time_detect_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_utc_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_daylight
);

    localparam int unsigned LAST = pdt_pkg::CIVIL_STAGES - 1;

    logic        adv;

    logic [50:0] p1;
    logic        valid1_reg;
    logic [15:0] qd1_reg;
    logic [31:0] secs1_reg;

    logic [25:0] rem2_full;
    logic [10:0] rem2;
    logic        ge2;
    logic [9:0]  r2;
    logic        valid2_reg;
    logic [15:0] days2_next, days2_reg;
    logic [16:0] sod2_next, sod2_reg;

    logic        valid_line_reg [pdt_pkg::CIVIL_STAGES];
    logic [15:0] days_line_reg  [pdt_pkg::CIVIL_STAGES];
    logic [16:0] sod_line_reg   [pdt_pkg::CIVIL_STAGES];
    pdt_pkg::date_t date;

    logic [15:0] x11_next, x11_reg;
    logic [32:0] p11;
    logic [12:0] q11_reg;
    logic        valid11_reg;
    pdt_pkg::date_t date11_reg;
    logic [16:0] sod11_reg;

    logic [15:0] r12;
    logic [2:0]  dow12_next, dow12_reg;
    logic        valid12_reg;
    pdt_pkg::date_t date12_reg;
    logic [16:0] sod12_reg;

    logic [3:0]  first_sunday;
    logic [4:0]  change;
    logic        daylight_next;
    logic        m_valid_reg;
    logic        m_daylight_reg;

    assign adv = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_daylight = m_daylight_reg;

    assign p1 = 51'(s_utc_seconds[31:7]) * 51'(pdt_pkg::RECIP_675);

    always_comb begin
        rem2_full = 26'(secs1_reg[31:7]) - 26'(qd1_reg) * 26'(pdt_pkg::DAY_CHUNK);
        rem2 = rem2_full[10:0];
        ge2 = (rem2 >= 11'(pdt_pkg::DAY_CHUNK));
        r2 = ge2 ? 10'(rem2 - 11'(pdt_pkg::DAY_CHUNK)) : rem2[9:0];
        days2_next = qd1_reg + 16'(ge2);
        sod2_next = {r2, secs1_reg[6:0]};
    end

    pdt_civil_date u_civil (
        .aclk (aclk),
        .en   (adv),
        .days (days2_reg),
        .date (date)
    );

    always_comb begin
        x11_next = days_line_reg[LAST] + pdt_pkg::WEEKDAY_BIAS - 16'(date.mday);
        p11 = 33'(x11_next) * 33'(pdt_pkg::RECIP_7);
    end

    always_comb begin
        r12 = x11_reg - 16'(q11_reg) * pdt_pkg::WEEK_DAYS;
        dow12_next = (r12 >= pdt_pkg::WEEK_DAYS) ? 3'(r12 - pdt_pkg::WEEK_DAYS) : r12[2:0];
    end

    always_comb begin
        first_sunday = (dow12_reg == 3'd0) ? 4'd1 : 4'd8 - 4'(dow12_reg);
        if (date12_reg.month == pdt_pkg::MONTH_MARCH) begin
            change = 5'(first_sunday) + 5'd7;
        end else begin
            change = 5'(first_sunday);
        end
        if (date12_reg.month < pdt_pkg::MONTH_MARCH ||
            date12_reg.month > pdt_pkg::MONTH_NOVEMBER) begin
            daylight_next = 1'b0;
        end else if (date12_reg.month > pdt_pkg::MONTH_MARCH &&
                     date12_reg.month < pdt_pkg::MONTH_NOVEMBER) begin
            daylight_next = 1'b1;
        end else if (date12_reg.month == pdt_pkg::MONTH_MARCH) begin
            if (date12_reg.mday < change) begin
                daylight_next = 1'b0;
            end else if (date12_reg.mday > change) begin
                daylight_next = 1'b1;
            end else begin
                daylight_next = (sod12_reg >= pdt_pkg::SPRING_SOD);
            end
        end else begin
            if (date12_reg.mday < change) begin
                daylight_next = 1'b1;
            end else if (date12_reg.mday > change) begin
                daylight_next = 1'b0;
            end else begin
                daylight_next = (sod12_reg < pdt_pkg::FALL_SOD);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg  <= 1'b0;
            valid2_reg  <= 1'b0;
            valid11_reg <= 1'b0;
            valid12_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < pdt_pkg::CIVIL_STAGES; i++) begin
                valid_line_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            valid1_reg  <= s_valid;
            valid2_reg  <= valid1_reg;
            valid_line_reg[0] <= valid2_reg;
            for (int i = 1; i < pdt_pkg::CIVIL_STAGES; i++) begin
                valid_line_reg[i] <= valid_line_reg[i - 1];
            end
            valid11_reg <= valid_line_reg[LAST];
            valid12_reg <= valid11_reg;
            m_valid_reg <= valid12_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            qd1_reg   <= p1[50:35];
            secs1_reg <= s_utc_seconds;
            days2_reg <= days2_next;
            sod2_reg  <= sod2_next;
            days_line_reg[0] <= days2_reg;
            sod_line_reg[0]  <= sod2_reg;
            for (int i = 1; i < pdt_pkg::CIVIL_STAGES; i++) begin
                days_line_reg[i] <= days_line_reg[i - 1];
                sod_line_reg[i]  <= sod_line_reg[i - 1];
            end
            x11_reg    <= x11_next;
            q11_reg    <= p11[31:19];
            date11_reg <= date;
            sod11_reg  <= sod_line_reg[LAST];
            dow12_reg  <= dow12_next;
            date12_reg <= date11_reg;
            sod12_reg  <= sod11_reg;
            m_daylight_reg <= daylight_next;
        end
    end

endmodule

// ===== src/pdt_civil_date.sv =====
module pdt_civil_date (
    input  logic            aclk,
    input  logic            en,
    input  logic [15:0]     days,
    output pdt_pkg::date_t  date
);

    logic [19:0] z;
    logic [17:0] doe3_next, doe3_reg;

    logic [36:0] p4;
    logic [6:0]  a4_next, a4_reg;
    logic [2:0]  cent4_next, cent4_reg;
    logic        last4_next, last4_reg;
    logic [17:0] doe4_reg;

    logic [17:0] rem5;
    logic [6:0]  a5;
    logic [17:0] t5_next, t5_reg, doe5_reg;

    logic [36:0] p6;
    logic [8:0]  y6_next, y6_reg;
    logic [17:0] t6_reg, doe6_reg;

    logic [17:0] rem7;
    logic [8:0]  yoe7_next, yoe7_reg;
    logic [17:0] doe7_reg;

    logic [17:0] base8;
    logic [17:0] cent8;
    logic [8:0]  doy8_next, doy8_reg;

    logic [3:0]  mp9_next, mp9_reg;
    logic [8:0]  doy9_reg;

    pdt_pkg::date_t date_next, date_reg;

    always_comb begin
        z = 20'(days) + pdt_pkg::EPOCH_SHIFT;
        if (z >= pdt_pkg::ERA5_BASE) begin
            doe3_next = 18'(z - pdt_pkg::ERA5_BASE);
        end else begin
            doe3_next = 18'(z - pdt_pkg::ERA4_BASE);
        end
    end

    always_comb begin
        p4 = 37'(doe3_reg) * 37'(pdt_pkg::RECIP_1460);
        a4_next = p4[35:29];
        cent4_next = 3'(doe3_reg >= pdt_pkg::CENT_DAYS)
                   + 3'(doe3_reg >= 18'(2 * pdt_pkg::CENT_DAYS))
                   + 3'(doe3_reg >= 18'(3 * pdt_pkg::CENT_DAYS))
                   + 3'(doe3_reg >= pdt_pkg::ERA_LAST);
        last4_next = (doe3_reg == pdt_pkg::ERA_LAST);
    end

    always_comb begin
        rem5 = doe4_reg - 18'(a4_reg) * pdt_pkg::QUAD_DAYS;
        a5 = a4_reg + 7'(rem5 >= pdt_pkg::QUAD_DAYS);
        t5_next = doe4_reg - 18'(a5) + 18'(cent4_reg) - 18'(last4_reg);
    end

    always_comb begin
        p6 = 37'(t5_reg) * 37'(pdt_pkg::RECIP_365);
        y6_next = p6[35:27];
    end

    always_comb begin
        rem7 = t6_reg - 18'(y6_reg) * pdt_pkg::YEAR_DAYS;
        yoe7_next = y6_reg + 9'(rem7 >= pdt_pkg::YEAR_DAYS);
    end

    always_comb begin
        cent8 = 18'(yoe7_reg >= 9'd100) + 18'(yoe7_reg >= 9'd200) + 18'(yoe7_reg >= 9'd300);
        base8 = 18'(yoe7_reg) * pdt_pkg::YEAR_DAYS + 18'(yoe7_reg >> 2) - cent8;
        doy8_next = 9'(doe7_reg - base8);
    end

    always_comb begin
        mp9_next = 4'd0;
        for (int i = 1; i < 12; i++) begin
            mp9_next = mp9_next + 4'(doy8_reg >= pdt_pkg::month_start(4'(i)));
        end
    end

    always_comb begin
        date_next.mday = 5'(doy9_reg - pdt_pkg::month_start(mp9_reg) + 9'd1);
        if (mp9_reg < 4'd10) begin
            date_next.month = mp9_reg + 4'd3;
        end else begin
            date_next.month = mp9_reg - 4'd9;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            doe3_reg  <= doe3_next;
            a4_reg    <= a4_next;
            cent4_reg <= cent4_next;
            last4_reg <= last4_next;
            doe4_reg  <= doe3_reg;
            t5_reg    <= t5_next;
            doe5_reg  <= doe4_reg;
            y6_reg    <= y6_next;
            t6_reg    <= t5_reg;
            doe6_reg  <= doe5_reg;
            yoe7_reg  <= yoe7_next;
            doe7_reg  <= doe6_reg;
            doy8_reg  <= doy8_next;
            mp9_reg   <= mp9_next;
            doy9_reg  <= doy8_reg;
            date_reg  <= date_next;
        end
    end

    assign date = date_reg;

endmodule

// ===== src/pdt_checker.sv =====
module pdt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [31:0] s_utc_seconds,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_daylight
);

    // A held output word keeps its value until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_daylight))
        else $error("output word changed while stalled");

    // Reset leaves no word at the output.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // An empty output stage never blocks the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // A word taken at the output frees the pipeline for a new input word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> s_ready)
        else $error("input stalled while output drains");

    // Without an output stall the input is never refused.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input refused without an output stall");

endmodule

bind pacific_daylight_time_detect_unit pdt_checker u_pdt_checker (.*);
